/* hdl/vap_pkg.sv */
// Package of the vertex attribute packer.
// Holds the shared constants and types; depends on nothing.
package vap_pkg;

   localparam logic [15:0] HALF_INF     = 16'h7C00;
   localparam int          SGL_MAN_W    = 23;
   localparam int          PROD_W       = 34;
   localparam int          NORMAL_XY_W  = 11;
   localparam int          SNORM_W      = 10;
   localparam logic [1:0]  HAND_POS     = 2'd1;
   localparam logic [1:0]  HAND_NEG     = 2'd3;

   typedef enum logic [2:0] {
      CLS_ZERO  = 3'b001,
      CLS_CLAMP = 3'b010,
      CLS_ROUND = 3'b100
   } snorm_class_type;

   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
   } stage_enable_type;

endpackage

/* hdl/vap_half_conv.sv */
// Single to half precision conversion, combinational.
// Depends on vap_pkg.
module vap_half_conv (
   input  logic [31:0] sgl,
   output logic [15:0] half
);
   import vap_pkg::*;

   logic [7:0]  exp_w;
   logic [23:0] man_w;
   logic [15:0] sign_w;
   logic [4:0]  sh_w;
   logic [23:0] den_w;
   logic        rnd_w;
   logic [15:0] nrm_w;

   always_comb begin
      exp_w  = sgl[30:23];
      man_w  = {1'b1, sgl[22:0]};
      sign_w = {sgl[31], 15'd0};
      sh_w   = 5'(8'd126 - exp_w);
      den_w  = man_w >> sh_w;
      rnd_w  = man_w[sh_w - 5'd1];
      nrm_w  = sign_w | {1'b0, 5'(exp_w - 8'd112), sgl[22:13]};
      if (exp_w < 8'd102) begin
         half = sign_w;
      end else if (exp_w <= 8'd112) begin
         half = sign_w | (den_w[15:0] + {15'd0, rnd_w});
      end else if (exp_w >= 8'd143) begin
         half = sign_w | HALF_INF;
      end else begin
         half = nrm_w + {15'd0, sgl[12]};
      end
   end

endmodule

/* hdl/vap_snorm_unit.sv */
// Three-stage signed-normalized converter: float32 product, round, clamp.
// Depends on vap_pkg; stage enables come from the top level.
module vap_snorm_unit #(
   parameter int W = 10
) (
   input  logic                       clock,
   input  vap_pkg::stage_enable_type  en,
   input  logic [31:0]                bits,
   output logic [W-1:0]               value
);
   import vap_pkg::*;

   localparam int SCALE = (1 << (W - 1)) - 1;

   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [3:0]          ka_ff, ka_in, kb_ff;
   logic                nega_ff, nega_in, negb_ff;
   snorm_class_type     clsa_ff, clsa_in, clsb_ff;
   logic [PROD_W:0]     rnd_ff, rnd_in;
   logic [W-1:0]        value_ff, value_in;

   logic [7:0]          exp_w;
   logic [3:0]          d_w;
   logic [PROD_W-1:0]   q_w, mask_w;
   logic                up_w;
   logic [5:0]          k_w;
   logic [PROD_W+1:0]   sum_w;
   logic [11:0]         t_w, tc_w;

   always_comb begin
      exp_w   = bits[30:23];
      nega_in = bits[31];
      prod_in = PROD_W'({1'b1, bits[22:0]}) * PROD_W'(SCALE);
      ka_in   = 4'(8'd126 - exp_w);
      if (exp_w == 8'd255 && bits[22:0] != 23'd0) begin
         clsa_in = CLS_ZERO;
      end else if (exp_w >= 8'd127) begin
         clsa_in = CLS_CLAMP;
      end else if (exp_w <= 8'd114) begin
         clsa_in = CLS_ZERO;
      end else begin
         clsa_in = CLS_ROUND;
      end
   end

   always_comb begin
      d_w    = prod_ff[PROD_W-1] ? 4'd10 : (prod_ff[PROD_W-2] ? 4'd9 : 4'd8);
      q_w    = prod_ff >> d_w;
      mask_w = (PROD_W'(1) << (d_w - 4'd1)) - PROD_W'(1);
      up_w   = prod_ff[d_w - 4'd1] & ((|(prod_ff & mask_w)) | q_w[0]);
      rnd_in = (PROD_W+1)'(q_w + PROD_W'(up_w)) << d_w;
   end

   always_comb begin
      k_w   = 6'(kb_ff) + 6'd24;
      sum_w = {1'b0, rnd_ff} + ((PROD_W+2)'(1) << (k_w - 6'd1));
      t_w   = 12'(sum_w >> k_w);
      case (clsb_ff)
         CLS_ZERO:  tc_w = 12'd0;
         CLS_CLAMP: tc_w = 12'(SCALE);
         CLS_ROUND: tc_w = (t_w > 12'(SCALE)) ? 12'(SCALE) : t_w;
         default:   tc_w = 12'd0;
      endcase
      value_in = W'(negb_ff ? (~tc_w + 12'd1) : tc_w);
   end

   always_ff @(posedge clock) begin
      if (en.s1) begin
         prod_ff <= prod_in;
         ka_ff   <= ka_in;
         nega_ff <= nega_in;
         clsa_ff <= clsa_in;
      end
      if (en.s2) begin
         rnd_ff  <= rnd_in;
         kb_ff   <= ka_ff;
         negb_ff <= nega_ff;
         clsb_ff <= clsa_ff;
      end
      if (en.s3) begin
         value_ff <= value_in;
      end
   end

   assign value = value_ff;

endmodule

/* hdl/vertex_attribute_packer_unit.sv */
// Top level of the vertex attribute packer: three-stage pipeline.
// Depends on vap_pkg, vap_half_conv and vap_snorm_unit.
//
// Usage: one vertex is transferred on the req_ channel when req_valid is
// high and req_stall is low; its packed result leaves on the rsp_ channel
// under the same rule with rsp_valid and rsp_stall.
// A vertex is registered in the first, second and third stage in turn;
// rsp_valid is the valid bit of the third stage.
// Throughput is one vertex per cycle while the receiver does not stall;
// the three register stages are the single-precision multiply, the float
// rounding of the product and the final integer rounding and clamp, with
// half conversion between the first and second stage.
// Reset clears the stage valid bits, so no result is shown after reset.
// When the receiver stalls, the last stage holds its result and each
// earlier stage holds once it is full and the one after it holds; req_stall
// rises once the whole pipeline is full, and no vertex is lost or repeated.
module vertex_attribute_packer_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_position_x,
   input  logic [31:0] req_position_y,
   input  logic [31:0] req_position_z,
   input  logic [31:0] req_normal_x,
   input  logic [31:0] req_normal_y,
   input  logic [31:0] req_normal_z,
   input  logic [31:0] req_tex_u,
   input  logic [31:0] req_tex_v,
   input  logic [31:0] req_tangent_x,
   input  logic [31:0] req_tangent_y,
   input  logic [31:0] req_tangent_z,
   input  logic        req_tangent_negative,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_half_pos_x,
   output logic [15:0] rsp_half_pos_y,
   output logic [15:0] rsp_half_pos_z,
   output logic [31:0] rsp_packed_normal,
   output logic [15:0] rsp_half_tex_u,
   output logic [15:0] rsp_half_tex_v,
   output logic [31:0] rsp_packed_tangent
);
   import vap_pkg::*;

   stage_enable_type en;
   logic v1_ff, v2_ff, v3_ff;

   logic [31:0] raw1_ff [5];
   logic        neg1_ff, neg2_ff;
   logic [15:0] half_in [5];
   logic [15:0] half2_ff [5];
   logic [15:0] half3_ff [5];
   logic [1:0]  hand3_ff;

   logic [NORMAL_XY_W-1:0] nx_w, ny_w;
   logic [SNORM_W-1:0]     nz_w, tx_w, ty_w, tz_w;

   always_comb begin
      en.s3     = !v3_ff || !rsp_stall;
      en.s2     = !v2_ff || en.s3;
      en.s1     = !v1_ff || en.s2;
      req_stall = !en.s1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (en.s1) v1_ff <= req_valid;
         if (en.s2) v2_ff <= v1_ff;
         if (en.s3) v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en.s1) begin
         raw1_ff[0] <= req_position_x;
         raw1_ff[1] <= req_position_y;
         raw1_ff[2] <= req_position_z;
         raw1_ff[3] <= req_tex_u;
         raw1_ff[4] <= req_tex_v;
         neg1_ff    <= req_tangent_negative;
      end
      if (en.s2) begin
         half2_ff <= half_in;
         neg2_ff  <= neg1_ff;
      end
      if (en.s3) begin
         half3_ff <= half2_ff;
         hand3_ff <= neg2_ff ? HAND_NEG : HAND_POS;
      end
   end

   for (genvar i = 0; i < 5; i++) begin : g_half
      vap_half_conv u_half (.sgl(raw1_ff[i]), .half(half_in[i]));
   end

   vap_snorm_unit #(.W(NORMAL_XY_W)) u_nx (.clock, .en, .bits(req_normal_x),
      .value(nx_w));
   vap_snorm_unit #(.W(NORMAL_XY_W)) u_ny (.clock, .en, .bits(req_normal_y),
      .value(ny_w));
   vap_snorm_unit #(.W(SNORM_W)) u_nz (.clock, .en, .bits(req_normal_z),
      .value(nz_w));
   vap_snorm_unit #(.W(SNORM_W)) u_tx (.clock, .en, .bits(req_tangent_x),
      .value(tx_w));
   vap_snorm_unit #(.W(SNORM_W)) u_ty (.clock, .en, .bits(req_tangent_y),
      .value(ty_w));
   vap_snorm_unit #(.W(SNORM_W)) u_tz (.clock, .en, .bits(req_tangent_z),
      .value(tz_w));

   assign rsp_valid          = v3_ff;
   assign rsp_half_pos_x     = half3_ff[0];
   assign rsp_half_pos_y     = half3_ff[1];
   assign rsp_half_pos_z     = half3_ff[2];
   assign rsp_half_tex_u     = half3_ff[3];
   assign rsp_half_tex_v     = half3_ff[4];
   assign rsp_packed_normal  = {nz_w, ny_w, nx_w};
   assign rsp_packed_tangent = {hand3_ff, tz_w, ty_w, tx_w};

`ifndef SYNTHESIS
   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> v1_ff)
      else $error("transfer in did not reach the first stage");
   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      v2_ff && !en.s3 |=> v2_ff && v3_ff)
      else $error("stalled second stage lost its item");
   a_hand_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_packed_tangent[30])
      else $error("handedness code malformed");
`endif

endmodule
